// File: sv/tpcr_pkg.sv
// Package for the two-track position code reader.
// Holds widths, register indexes, shared structs and the ID extraction function.
// No dependencies.
package tpcr_pkg;

  // Code length and field widths.
  localparam int CODE_BITS  = 8;
  localparam int CNT_W      = $clog2(CODE_BITS + 1);
  localparam int SAMPLE_W   = 12;
  localparam int TIME_W     = 32;
  localparam int TIMEOUT_W  = 16;
  localparam int ID_W       = 8;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_ADDR_W = 2;
  localparam int PAD_W      = (CODE_BITS > ID_W) ? CODE_BITS : ID_W;

  // Reset values of the configuration registers.
  localparam logic [SAMPLE_W-1:0]  WHITE_A_RST = SAMPLE_W'(1100);
  localparam logic [SAMPLE_W-1:0]  WHITE_B_RST = SAMPLE_W'(1750);
  localparam logic [SAMPLE_W-1:0]  LEAVE_RST   = SAMPLE_W'(3950);
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(250);

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_WHITE_A = 2'd0,
    REG_WHITE_B = 2'd1,
    REG_LEAVE   = 2'd2,
    REG_TIMEOUT = 2'd3
  } cfg_reg_e;

  // Current configuration as seen by the datapath.
  typedef struct packed {
    logic [SAMPLE_W-1:0]  white_a;
    logic [SAMPLE_W-1:0]  white_b;
    logic [SAMPLE_W-1:0]  leave;
    logic [TIMEOUT_W-1:0] timeout;
  } cfg_t;

  // Bit store and fill count of one channel.
  typedef struct packed {
    logic [CODE_BITS-1:0] bits;
    logic [CNT_W-1:0]     count;
  } chan_t;

  // Status flags a channel hands to the rest of the step.
  typedef struct packed {
    logic complete;
    logic clear_both;
  } chan_stat_t;

  // Low ID_W bits of a code, zero-extended when the code is shorter.
  function automatic logic [ID_W-1:0] id_of(input logic [CODE_BITS-1:0] bits);
    logic [PAD_W-1:0] pad;
    pad = PAD_W'(bits);
    return pad[ID_W-1:0];
  endfunction

endpackage

// File: sv/two_track_position_code_reader_core.sv
// Two-track position code reader, top level.
// Flow: an accepted beat is held in the input register and is loaded into the
// result register once the output is free; its result is then shown until it
// is taken. Throughput: one beat per cycle while the output is not stalled,
// set by the single state-update stage between the input register
// and the result register.
// Reset: asynchronous active low; it clears both channels, the last colours,
// the edge times and the valid flags, and loads the register reset values.
module two_track_position_code_reader_core
  import tpcr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [SAMPLE_W-1:0]   sample_a_i,
  input  logic [SAMPLE_W-1:0]   sample_b_i,
  input  logic [TIME_W-1:0]     time_ms_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [ID_W-1:0]       position_id_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t cfg;

  logic                s1_valid_q;
  logic [SAMPLE_W-1:0] s1_sa_q;
  logic [SAMPLE_W-1:0] s1_sb_q;
  logic [TIME_W-1:0]   s1_time_q;
  logic                out_valid_q;
  logic [ID_W-1:0]     out_id_q;

  logic                last_a_q;
  logic                last_b_q;
  chan_t               chan_a_q;
  chan_t               chan_b_q;
  logic [TIME_W-1:0]   edge_a_q;
  logic [TIME_W-1:0]   edge_b_q;

  logic                advance;
  logic                col_a;
  logic                col_b;
  chan_t               chan_a_new;
  chan_t               chan_b_mid;
  chan_t               chan_b_new;
  chan_t               chan_a_d;
  logic [TIME_W-1:0]   edge_a_d;
  logic [TIME_W-1:0]   edge_b_d;
  chan_stat_t          stat_a;
  chan_stat_t          stat_b;
  logic [ID_W-1:0]     id_a;
  logic [ID_W-1:0]     id_b;
  logic [ID_W-1:0]     id_d;

  tpcr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Handshake: the input register moves on when the result register is free.
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || !out_valid_q || out_ready_i;

  // Threshold both samples to white (1) or black (0).
  assign col_a = s1_sa_q < cfg.white_a;
  assign col_b = s1_sb_q < cfg.white_b;

  // Channel A: data on track one, clocked by track two.
  tpcr_chan u_chan_a (
    .state_i     (chan_a_q),
    .edge_time_i (edge_a_q),
    .strobe_i    (col_b != last_b_q),
    .data_bit_i  (col_a),
    .leave_i     (s1_sa_q > cfg.leave),
    .now_i       (s1_time_q),
    .timeout_i   (cfg.timeout),
    .state_o     (chan_a_new),
    .edge_time_o (edge_a_d),
    .stat_o      (stat_a),
    .id_o        (id_a)
  );

  // Channel B sees its store as channel A left it.
  assign chan_b_mid = stat_a.clear_both ? '0 : chan_b_q;

  tpcr_chan u_chan_b (
    .state_i     (chan_b_mid),
    .edge_time_i (edge_b_q),
    .strobe_i    (col_a != last_a_q),
    .data_bit_i  (col_b),
    .leave_i     (s1_sb_q > cfg.leave),
    .now_i       (s1_time_q),
    .timeout_i   (cfg.timeout),
    .state_o     (chan_b_new),
    .edge_time_o (edge_b_d),
    .stat_o      (stat_b),
    .id_o        (id_b)
  );

  // A completion or leave on channel B also clears channel A; B's ID wins.
  assign chan_a_d = stat_b.clear_both ? '0 : chan_a_new;
  assign id_d     = stat_b.complete ? id_b : id_a;

  // Control and channel state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      last_a_q    <= 1'b0;
      last_b_q    <= 1'b0;
      chan_a_q    <= '0;
      chan_b_q    <= '0;
      edge_a_q    <= '0;
      edge_b_q    <= '0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        last_a_q    <= col_a;
        last_b_q    <= col_b;
        chan_a_q    <= chan_a_d;
        chan_b_q    <= chan_b_new;
        edge_a_q    <= edge_a_d;
        edge_b_q    <= edge_b_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_sa_q   <= sample_a_i;
      s1_sb_q   <= sample_b_i;
      s1_time_q <= time_ms_i;
    end
    if (advance) begin
      out_id_q <= id_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign position_id_o = out_id_q;

endmodule

// File: sv/tpcr_cfg_regs.sv
// Configuration register file of the position code reader.
// Depends on tpcr_pkg for widths, indexes and the cfg_t struct.
module tpcr_cfg_regs
  import tpcr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  // Write the addressed register; values are cut to the register width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.white_a <= WHITE_A_RST;
      cfg_q.white_b <= WHITE_B_RST;
      cfg_q.leave   <= LEAVE_RST;
      cfg_q.timeout <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_WHITE_A: cfg_q.white_a <= cfg_wdata_i[SAMPLE_W-1:0];
        REG_WHITE_B: cfg_q.white_b <= cfg_wdata_i[SAMPLE_W-1:0];
        REG_LEAVE:   cfg_q.leave   <= cfg_wdata_i[SAMPLE_W-1:0];
        REG_TIMEOUT: cfg_q.timeout <= cfg_wdata_i[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/tpcr_chan.sv
// Next-state logic of one reader channel: clock in a bit, detect a full code,
// apply the leave and timeout clears. Depends on tpcr_pkg.
module tpcr_chan
  import tpcr_pkg::*;
(
  input  chan_t                 state_i,
  input  logic [TIME_W-1:0]     edge_time_i,
  input  logic                  strobe_i,
  input  logic                  data_bit_i,
  input  logic                  leave_i,
  input  logic [TIME_W-1:0]     now_i,
  input  logic [TIMEOUT_W-1:0]  timeout_i,
  output chan_t                 state_o,
  output logic [TIME_W-1:0]     edge_time_o,
  output chan_stat_t            stat_o,
  output logic [ID_W-1:0]       id_o
);

  logic [CODE_BITS-1:0] bits_set;
  logic [CNT_W-1:0]     cnt_inc;
  logic [TIME_W-1:0]    age;
  logic                 complete;
  logic                 timed_out;

  // A clocking edge restarts the edge timer and stores the data bit.
  assign edge_time_o = strobe_i ? now_i : edge_time_i;
  assign bits_set    = state_i.bits | (CODE_BITS'(data_bit_i) << state_i.count);
  assign cnt_inc     = state_i.count + CNT_W'(1);
  assign complete    = strobe_i && (cnt_inc == CNT_W'(CODE_BITS));

  // Age of the last edge, modulo the time stamp width.
  assign age       = now_i - edge_time_o;
  assign timed_out = age > TIME_W'(timeout_i);

  assign stat_o.complete   = complete;
  assign stat_o.clear_both = complete || leave_i;

  // Any clear wins over the freshly clocked bit.
  always_comb begin
    if (complete || leave_i || timed_out) begin
      state_o = '0;
    end else if (strobe_i) begin
      state_o.bits  = bits_set;
      state_o.count = cnt_inc;
    end else begin
      state_o = state_i;
    end
  end

  assign id_o = complete ? id_of(bits_set) : '0;

endmodule

// File: sv/tpcr_checker.sv
// Port-level checks for the position code reader, bound to the top level.
// Depends on tpcr_pkg and two_track_position_code_reader_core.
module tpcr_checker
  import tpcr_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [ID_W-1:0]       position_id_o
);

  // A stalled result beat holds its ID.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(position_id_o))
    else $error("result beat dropped or changed while stalled");

  // The input only stalls when a result is waiting and not taken.
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while the output could move");

  // A result appearing on an empty output comes from an accepted input beat, via the input and result registers.
  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result beat without a matching input beat");

  // With the output kept ready, an accepted beat yields a valid result.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && out_ready_i ##1 out_ready_i |=> out_valid_o)
    else $error("result beat missing after accepted input");

endmodule

bind two_track_position_code_reader_core tpcr_checker u_tpcr_checker (.*);
